### rtl/core/cstc_pkg.sv
package cstc_pkg;

   // field widths of the request and response beats
   localparam int ID_W    = 17;
   localparam int LIM_W   = 16;
   localparam int TIME_W  = 48;
   localparam int SLEEP_W = 36;
   localparam int ST_W    = 3;
   localparam int REQ_W   = 2;

   // defaults handed to the top level parameters
   localparam int MAX_TASKS_DEF = 16;
   localparam int FRAC_BITS_DEF = 12;

   // shared serial divider: remainder/divisor width, sleep quotient width
   localparam int DIV_W  = 70;
   localparam int QUO_W  = 54;
   localparam int CNT_W  = $clog2(QUO_W + 1);
   localparam int LOAD_Q = LIM_W;

   localparam logic [ID_W-1:0]    ID_MAX         = ID_W'(99999);
   localparam logic [SLEEP_W-1:0] INTERVAL_RESET = SLEEP_W'(64'd3000000000);

   // request codes on the wire
   localparam logic [REQ_W-1:0] REQ_SET    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
   localparam logic [REQ_W-1:0] REQ_RESET  = 2'd3;

   // response status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_FIRST    = 3'd1;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
   localparam logic [ST_W-1:0] ST_BADID    = 3'd4;

   // operation after classification in the front end
   typedef enum logic [2:0] {
      OP_SET,
      OP_SAMPLE,
      OP_REMOVE,
      OP_RESET_STATS,
      OP_BAD_ID
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     task_id;
      logic [LIM_W-1:0]    limit;
      logic [TIME_W-1:0]   now;
   } job_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EXEC,
      BK_LOAD_DIV,
      BK_MUL,
      BK_PREP,
      BK_SLEEP_DIV,
      BK_FIN,
      BK_RESP
   } back_state_type;

endpackage

### rtl/core/cstc_if.sv
interface cstc_req_if
   import cstc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [ID_W-1:0]    task_id;
   logic [LIM_W-1:0]   share_limit;
   logic [TIME_W-1:0]  cpu_time_ns;
   modport source (output valid, req_type, task_id, share_limit, cpu_time_ns, input ready);
   modport sink   (input valid, req_type, task_id, share_limit, cpu_time_ns, output ready);
endinterface

interface cstc_rsp_if
   import cstc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     task_ref;
   logic [SLEEP_W-1:0]  sleep_ns;
   logic [ST_W-1:0]     status;
   modport source (output valid, task_ref, sleep_ns, status, input ready);
   modport sink   (input valid, task_ref, sleep_ns, status, output ready);
endinterface

### rtl/core/cstc_front.sv
module cstc_front
   import cstc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   cstc_req_if.sink     req_chan,
   input  logic         job_pop,
   output logic         job_valid,
   output job_type      job
);

   localparam int QDEPTH = 2;

   job_type    q_ff [QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   job_type    cls;
   logic       push;

   // classify the incoming beat
   always_comb begin
      cls.task_id = req_chan.task_id;
      cls.limit   = req_chan.share_limit;
      cls.now     = req_chan.cpu_time_ns;
      if (req_chan.req_type == REQ_RESET) begin
         cls.op = OP_RESET_STATS;
      end else if (req_chan.task_id == '0 || req_chan.task_id > ID_MAX) begin
         cls.op = OP_BAD_ID;
      end else begin
         case (req_chan.req_type)
            REQ_SET:    cls.op = OP_SET;
            REQ_SAMPLE: cls.op = OP_SAMPLE;
            REQ_REMOVE: cls.op = OP_REMOVE;
            default:    cls.op = OP_BAD_ID;
         endcase
      end
   end

   assign req_chan.ready = (count_ff != 2'(QDEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign job_valid      = (count_ff != 2'd0);
   assign job            = q_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(job_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/core/cstc_back.sv
module cstc_back
   import cstc_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  job_type             job,
   output logic                job_pop,
   input  logic [SLEEP_W-1:0]  interval,
   cstc_rsp_if.source          rsp_chan
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_TASKS - 1);

   back_state_type state_ff, state_in;

   // task table
   logic                entry_valid_ff  [MAX_TASKS];
   logic                entry_primed_ff [MAX_TASKS];
   logic [ID_W-1:0]     entry_task_ff   [MAX_TASKS];
   logic [LIM_W-1:0]    entry_limit_ff  [MAX_TASKS];
   logic [TIME_W-1:0]   entry_time_ff   [MAX_TASKS];
   logic [SLEEP_W-1:0]  entry_sleep_ff  [MAX_TASKS];

   job_type             job_ff;
   logic [IDX_W-1:0]    idx_ff, hit_idx_ff, free_idx_ff;
   logic                hit_ff, free_ff;
   logic [SLEEP_W-1:0]  res_sleep_ff;
   logic [ST_W-1:0]     res_status_ff;
   logic [LIM_W-1:0]    load_ff;
   logic signed [QUO_W-1:0] num_ff;
   logic [LIM_W-1:0]    den_ff;
   logic                neg_ff;

   // shared serial divider
   logic [DIV_W-1:0]    rem_ff, dsr_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                ge;
   logic [DIV_W-1:0]    rem_nx;
   logic [QUO_W-1:0]    quo_nx;

   logic                rsp_valid_ff;
   logic [ID_W-1:0]     rsp_ref_ff;
   logic [SLEEP_W-1:0]  rsp_sleep_ff;
   logic [ST_W-1:0]     rsp_status_ff;
   logic                rsp_load;

   // entry fields at the hit slot
   logic [SLEEP_W-1:0]  hs;
   logic [LIM_W-1:0]    hl;
   logic [TIME_W-1:0]   diff;
   logic [DIV_W-1:0]    load_num;
   logic                load_sat;
   logic                scan_hit;
   logic                run_loop;
   logic signed [SLEEP_W:0] work;
   logic signed [LIM_W:0]   dlt;
   logic signed [QUO_W-1:0] prod;
   logic [LIM_W-1:0]    den_mx;
   logic [QUO_W-1:0]    num_mag;
   logic signed [QUO_W+1:0] qs, ssum;
   logic [SLEEP_W-1:0]  s_clamp;

   always_comb begin
      hs        = entry_sleep_ff[hit_idx_ff];
      hl        = entry_limit_ff[hit_idx_ff];
      diff      = job_ff.now - entry_time_ff[hit_idx_ff];
      load_num  = DIV_W'(diff) << FRAC_BITS;
      load_sat  = load_num >= (DIV_W'(interval) << LOAD_Q);
      scan_hit  = entry_valid_ff[idx_ff] && (entry_task_ff[idx_ff] == job_ff.task_id);
      run_loop  = (job_ff.op == OP_SAMPLE) && hit_ff && entry_primed_ff[hit_idx_ff]
                  && (interval != '0);
      ge        = rem_ff >= dsr_ff;
      rem_nx    = ge ? rem_ff - dsr_ff : rem_ff;
      quo_nx    = {quo_ff[QUO_W-2:0], ge};
      // work and load error
      work      = $signed({1'b0, interval}) - $signed({1'b0, hs});
      if (work == '0) begin
         work = $signed({1'b0, interval});
      end
      dlt       = $signed({1'b0, load_ff}) - $signed({1'b0, hl});
      prod      = work * dlt;
      den_mx    = (load_ff > hl) ? load_ff : hl;
      num_mag   = num_ff[QUO_W-1] ? QUO_W'(-num_ff) : QUO_W'(num_ff);
      // floored quotient and clamp
      if (neg_ff) begin
         qs = -$signed({2'b0, quo_ff}) - $signed((QUO_W+2)'(rem_ff != '0));
      end else begin
         qs = $signed({2'b0, quo_ff});
      end
      ssum = $signed((QUO_W+2)'(hs)) + qs;
      if (ssum < 0) begin
         s_clamp = '0;
      end else if (ssum > $signed((QUO_W+2)'(interval))) begin
         s_clamp = interval;
      end else begin
         s_clamp = ssum[SLEEP_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               if (job.op == OP_RESET_STATS || job.op == OP_BAD_ID) begin
                  state_in = BK_RESP;
               end else begin
                  state_in = BK_SCAN;
               end
            end
         end
         BK_SCAN:      if (idx_ff == LAST) state_in = BK_EXEC;
         BK_EXEC: begin
            if (run_loop) begin
               state_in = load_sat ? BK_MUL : BK_LOAD_DIV;
            end else begin
               state_in = BK_RESP;
            end
         end
         BK_LOAD_DIV:  if (cnt_ff == CNT_W'(1)) state_in = BK_MUL;
         BK_MUL:       state_in = BK_PREP;
         BK_PREP:      state_in = (den_ff == '0) ? BK_RESP : BK_SLEEP_DIV;
         BK_SLEEP_DIV: if (cnt_ff == CNT_W'(1)) state_in = BK_FIN;
         BK_FIN:       state_in = BK_RESP;
         BK_RESP:      if (!rsp_valid_ff || rsp_chan.ready) state_in = BK_IDLE;
         default:      state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop  = (state_ff == BK_IDLE) && job_valid;
      rsp_load = (state_ff == BK_RESP) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.task_ref = rsp_ref_ff;
   assign rsp_chan.sleep_ns = rsp_sleep_ff;
   assign rsp_chan.status   = rsp_status_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            entry_valid_ff[i]  <= 1'b0;
            entry_primed_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (job_pop && job.op == OP_RESET_STATS) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
               entry_primed_ff[i] <= 1'b0;
            end
         end
         if (state_ff == BK_EXEC && hit_ff) begin
            case (job_ff.op)
               OP_SET:    if (job_ff.limit == '0) entry_valid_ff[hit_idx_ff] <= 1'b0;
               OP_REMOVE: entry_valid_ff[hit_idx_ff] <= 1'b0;
               OP_SAMPLE: entry_primed_ff[hit_idx_ff] <= 1'b1;
               default:   ;
            endcase
         end
         if (state_ff == BK_EXEC && !hit_ff && free_ff && job_ff.op == OP_SET
             && job_ff.limit != '0) begin
            entry_valid_ff[free_idx_ff]  <= 1'b1;
            entry_primed_ff[free_idx_ff] <= 1'b0;
         end
      end
   end

   // datapath and table payload
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            job_ff        <= job;
            idx_ff        <= '0;
            hit_ff        <= 1'b0;
            free_ff       <= 1'b0;
            res_sleep_ff  <= '0;
            res_status_ff <= (job.op == OP_BAD_ID) ? ST_BADID : ST_OK;
            if (job_valid && job.op == OP_RESET_STATS) begin
               for (int i = 0; i < MAX_TASKS; i++) begin
                  if (entry_valid_ff[i]) begin
                     entry_time_ff[i]  <= '0;
                     entry_sleep_ff[i] <= '0;
                  end
               end
            end
         end
         BK_SCAN: begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (scan_hit && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= idx_ff;
            end
            if (!entry_valid_ff[idx_ff] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= idx_ff;
            end
         end
         BK_EXEC: begin
            case (job_ff.op)
               OP_SET: begin
                  if (hit_ff) begin
                     if (job_ff.limit != '0) begin
                        entry_limit_ff[hit_idx_ff] <= job_ff.limit;
                        res_sleep_ff               <= hs;
                     end
                  end else if (job_ff.limit == '0) begin
                     res_status_ff <= ST_NOTFOUND;
                  end else if (!free_ff) begin
                     res_status_ff <= ST_FULL;
                  end else begin
                     entry_task_ff[free_idx_ff]  <= job_ff.task_id;
                     entry_limit_ff[free_idx_ff] <= job_ff.limit;
                     entry_time_ff[free_idx_ff]  <= '0;
                     entry_sleep_ff[free_idx_ff] <= '0;
                  end
               end
               OP_REMOVE: begin
                  if (!hit_ff) res_status_ff <= ST_NOTFOUND;
               end
               OP_SAMPLE: begin
                  if (!hit_ff) begin
                     res_status_ff <= ST_NOTFOUND;
                  end else begin
                     entry_time_ff[hit_idx_ff] <= job_ff.now;
                     res_sleep_ff              <= hs;
                     if (!entry_primed_ff[hit_idx_ff]) res_status_ff <= ST_FIRST;
                  end
               end
               default: ;
            endcase
            // load = diff * 2^F / interval, saturated
            load_ff <= '1;
            rem_ff  <= load_num;
            dsr_ff  <= DIV_W'(interval) << (LOAD_Q - 1);
            quo_ff  <= '0;
            cnt_ff  <= CNT_W'(LOAD_Q);
         end
         BK_LOAD_DIV: begin
            rem_ff <= rem_nx;
            quo_ff <= quo_nx;
            dsr_ff <= dsr_ff >> 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) load_ff <= quo_nx[LIM_W-1:0];
         end
         BK_MUL: begin
            num_ff <= prod;
            den_ff <= den_mx;
         end
         BK_PREP: begin
            neg_ff <= num_ff[QUO_W-1];
            rem_ff <= DIV_W'(num_mag);
            dsr_ff <= DIV_W'(den_ff) << (QUO_W - 1);
            quo_ff <= '0;
            cnt_ff <= CNT_W'(QUO_W);
         end
         BK_SLEEP_DIV: begin
            rem_ff <= rem_nx;
            quo_ff <= quo_nx;
            dsr_ff <= dsr_ff >> 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         BK_FIN: begin
            entry_sleep_ff[hit_idx_ff] <= s_clamp;
            res_sleep_ff               <= s_clamp;
         end
         default: ;
      endcase
      if (rsp_load) begin
         rsp_ref_ff    <= job_ff.task_id;
         rsp_sleep_ff  <= res_sleep_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

endmodule

### rtl/core/cpu_share_throttle_controller_core.sv
// channel    | dir | handshake        | payload
// req_chan   | in  | valid/ready      | req_type, task_id, share_limit, cpu_time_ns
// rsp_chan   | out | valid/ready      | task_ref, sleep_ns, status
// csr_*      | in  | write enable     | schedule interval, 36 bits
//
// Reset stats and invalid ids go straight to the response; other requests scan
// the table one entry a cycle. A throttled sample adds the serial divider:
// 16 steps for the load (skipped when it saturates) and 54 for the sleep
// update. A two-beat queue lets requests land while the back end works or a
// response waits. Reset is synchronous and empties the table and the queue.
module cpu_share_throttle_controller_core
   import cstc_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   cstc_req_if.sink            req_chan,
   cstc_rsp_if.source          rsp_chan,
   input  logic                csr_we,
   input  logic [SLEEP_W-1:0]  csr_wdata
);

   logic [SLEEP_W-1:0] interval_ff;
   logic               job_valid, job_pop;
   job_type            job;

   // schedule interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_we) begin
         interval_ff <= csr_wdata;
      end
   end

   cstc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_pop   (job_pop),
      .job_valid (job_valid),
      .job       (job)
   );

   cstc_back #(
      .MAX_TASKS (MAX_TASKS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .interval  (interval_ff),
      .rsp_chan  (rsp_chan)
   );

endmodule

### verif/cpu_share_throttle_controller_core_tb.sv
module cpu_share_throttle_controller_core_tb;
   import cstc_pkg::*;

   localparam int NTASK        = MAX_TASKS_DEF;
   localparam int FRAC         = FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int POOL_N       = 24;
   localparam int N_RANDOM     = 1880;
   localparam logic [SLEEP_W-1:0] IV_MAX = {SLEEP_W{1'b1}};

   typedef struct {
      logic [ID_W-1:0]    id;
      logic [SLEEP_W-1:0] sleep;
      logic [ST_W-1:0]    status;
   } rsp_beat_t;

   typedef struct {
      logic [REQ_W-1:0]   req;
      logic [ID_W-1:0]    id;
      logic [LIM_W-1:0]   lim;
      logic [TIME_W-1:0]  tm;
      bit                 typed;
      logic [SLEEP_W-1:0] sleep;
      logic [ST_W-1:0]    status;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [SLEEP_W-1:0] csr_wdata = '0;

   cstc_req_if req_bus ();
   cstc_rsp_if rsp_bus ();

   cpu_share_throttle_controller_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus.sink),
      .rsp_chan  (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the task table
   logic [SLEEP_W-1:0] mdl_interval;
   bit                 mdl_valid  [NTASK];
   bit                 mdl_primed [NTASK];
   logic [ID_W-1:0]    mdl_id     [NTASK];
   logic [LIM_W-1:0]   mdl_lim    [NTASK];
   logic [TIME_W-1:0]  mdl_time   [NTASK];
   logic [SLEEP_W-1:0] mdl_sleep  [NTASK];

   rsp_beat_t pending_rsp [$];
   int errors = 0;
   int rsp_count = 0;
   int cycle = 0;
   bit steady_send = 0;

   // load of one period, Q4.12, saturating
   function automatic logic [LIM_W-1:0] period_load(logic [TIME_W-1:0] diff,
                                                    logic [SLEEP_W-1:0] iv);
      longint unsigned q, r, v;
      q = diff / iv;
      r = diff % iv;
      if (q >= (64'd1 << (16 - FRAC))) return '1;
      v = (q << FRAC) + ((r << FRAC) / iv);
      if (v > 64'hFFFF) v = 64'hFFFF;
      return v[LIM_W-1:0];
   endfunction

   // move the sleep time toward the share limit, floor division, clamped
   function automatic logic [SLEEP_W-1:0] next_sleep(logic [SLEEP_W-1:0] sl,
                                                     logic [LIM_W-1:0] lim,
                                                     logic [LIM_W-1:0] load,
                                                     logic [SLEEP_W-1:0] iv);
      longint w, num, den, q, s;
      w = longint'(iv) - longint'(sl);
      if (w == 0) w = longint'(iv);
      num = w * (longint'(load) - longint'(lim));
      den = (load > lim) ? longint'(load) : longint'(lim);
      if (den == 0) return sl;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      s = longint'(sl) + q;
      if (s < 0) s = 0;
      if (s > longint'(iv)) s = longint'(iv);
      return s[SLEEP_W-1:0];
   endfunction

   function automatic int find_task(logic [ID_W-1:0] id);
      for (int i = 0; i < NTASK; i++)
         if (mdl_valid[i] && mdl_id[i] == id) return i;
      return -1;
   endfunction

   // apply one accepted request to the shadow table, return its response
   function automatic rsp_beat_t throttle_predict(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                                  logic [LIM_W-1:0] lim,
                                                  logic [TIME_W-1:0] now);
      rsp_beat_t b;
      int k;
      logic [TIME_W-1:0] prev;
      b.id = id;
      b.sleep = '0;
      b.status = ST_OK;
      if (req == REQ_RESET) begin
         for (int i = 0; i < NTASK; i++)
            if (mdl_valid[i]) begin
               mdl_time[i] = '0;
               mdl_sleep[i] = '0;
               mdl_primed[i] = 0;
            end
      end else if (id == 0 || id > ID_MAX) begin
         b.status = ST_BADID;
      end else begin
         k = find_task(id);
         if (req == REQ_SET) begin
            if (k >= 0) begin
               if (lim == 0) mdl_valid[k] = 0;
               else begin
                  mdl_lim[k] = lim;
                  b.sleep = mdl_sleep[k];
               end
            end else if (lim == 0) begin
               b.status = ST_NOTFOUND;
            end else begin
               for (int i = NTASK - 1; i >= 0; i--)
                  if (!mdl_valid[i]) k = i;
               if (k < 0) b.status = ST_FULL;
               else begin
                  mdl_valid[k] = 1;
                  mdl_primed[k] = 0;
                  mdl_id[k] = id;
                  mdl_lim[k] = lim;
                  mdl_time[k] = '0;
                  mdl_sleep[k] = '0;
               end
            end
         end else if (k < 0) begin
            b.status = ST_NOTFOUND;
         end else if (req == REQ_REMOVE) begin
            mdl_valid[k] = 0;
         end else begin
            prev = mdl_time[k];
            mdl_time[k] = now;
            if (!mdl_primed[k]) begin
               mdl_primed[k] = 1;
               b.status = ST_FIRST;
            end else if (mdl_interval != 0) begin
               mdl_sleep[k] = next_sleep(mdl_sleep[k], mdl_lim[k],
                                         period_load(now - prev, mdl_interval), mdl_interval);
            end
            b.sleep = mdl_sleep[k];
         end
      end
      return b;
   endfunction

   // offer one request beat; predict on acceptance
   task automatic send_req(stim_row_t r);
      rsp_beat_t b;
      while (!steady_send && $urandom_range(99) < 9) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.req_type    <= r.req;
      req_bus.task_id     <= r.id;
      req_bus.share_limit <= r.lim;
      req_bus.cpu_time_ns <= r.tm;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      b = throttle_predict(r.req, r.id, r.lim, r.tm);
      if (r.typed) begin
         b.id = r.id;
         b.sleep = r.sleep;
         b.status = r.status;
      end
      pending_rsp.push_back(b);
   endtask

   task automatic drain_rsp();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // interval write only with the block idle
   task automatic write_interval(logic [SLEEP_W-1:0] v);
      drain_rsp();
      repeat (100) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      mdl_interval = v;
   endtask

   function automatic stim_row_t mk(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                    logic [LIM_W-1:0] lim, logic [TIME_W-1:0] tm,
                                    bit typed = 0, logic [SLEEP_W-1:0] sl = '0,
                                    logic [ST_W-1:0] st = ST_OK);
      stim_row_t r;
      r.req = req; r.id = id; r.lim = lim; r.tm = tm;
      r.typed = typed; r.sleep = sl; r.status = st;
      return r;
   endfunction

   // response side: random stalls, one long hold-off, compare in order
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      rsp_beat_t e;
      cycle <= cycle + 1;
      if (cycle > CYCLE_LIMIT) begin
         $display("cpu_share_throttle_controller_core_tb failed");
         $finish;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_count <= rsp_count + 1;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat id=%0d sleep=%0d status=%0d", $time,
                     rsp_bus.task_ref, rsp_bus.sleep_ns, rsp_bus.status);
            errors <= errors + 1;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_bus.task_ref !== e.id || rsp_bus.sleep_ns !== e.sleep ||
                rsp_bus.status !== e.status) begin
               $display("%0t: mismatch expected id=%0d sleep=%0d status=%0d actual id=%0d sleep=%0d status=%0d",
                        $time, e.id, e.sleep, e.status,
                        rsp_bus.task_ref, rsp_bus.sleep_ns, rsp_bus.status);
               errors <= errors + 1;
            end
         end
      end
      if (!hold_done && rsp_count == 1200) begin
         hold_done <= 1;
         hold_left <= 600;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_count >= 700 && rsp_count < 1000) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 9);
      end
   end

   // stimulus
   logic [ID_W-1:0]    pool_id   [POOL_N];
   logic [TIME_W-1:0]  pool_time [POOL_N];
   logic [SLEEP_W-1:0] phase_iv  [7];
   stim_row_t          dir_rows  [19];

   initial begin
      stim_row_t r;
      int p, sel, n_item;
      longint unsigned d;
      req_bus.valid = 1'b0;
      req_bus.req_type = '0;
      req_bus.task_id = '0;
      req_bus.share_limit = '0;
      req_bus.cpu_time_ns = '0;
      rsp_bus.ready = 1'b0;
      mdl_interval = INTERVAL_RESET;
      for (int i = 0; i < NTASK; i++) mdl_valid[i] = 0;

      dir_rows[0]  = mk(REQ_SAMPLE, 5, 0, 0, 1, 0, ST_NOTFOUND);
      dir_rows[1]  = mk(REQ_SET, 0, 100, 0, 1, 0, ST_BADID);
      dir_rows[2]  = mk(REQ_SET, 17'h1FFFF, 16'hFFFF, '1, 1, 0, ST_BADID);
      dir_rows[3]  = mk(REQ_SET, 99999, 16'hFFFF, 0, 1, 0, ST_OK);
      dir_rows[4]  = mk(REQ_SET, 1, 1, 0, 1, 0, ST_OK);
      dir_rows[5]  = mk(REQ_SAMPLE, 1, 0, 0, 1, 0, ST_FIRST);
      dir_rows[6]  = mk(REQ_SAMPLE, 1, 0, 48'd3000000000);
      dir_rows[7]  = mk(REQ_SAMPLE, 1, 0, '1);
      dir_rows[8]  = mk(REQ_SAMPLE, 1, 0, 5);               // time goes backward
      dir_rows[9]  = mk(REQ_SET, 1, 4096, 0);
      dir_rows[10] = mk(REQ_SAMPLE, 99999, 0, 0, 1, 0, ST_FIRST);
      dir_rows[11] = mk(REQ_SAMPLE, 99999, 0, 48'd1500000000);
      dir_rows[12] = mk(REQ_REMOVE, 7, 0, 0, 1, 0, ST_NOTFOUND);
      dir_rows[13] = mk(REQ_SET, 7, 0, 0, 1, 0, ST_NOTFOUND);
      dir_rows[14] = mk(REQ_REMOVE, 99999, 0, 0, 1, 0, ST_OK);
      dir_rows[15] = mk(REQ_RESET, 17'h1FFFF, 0, 0, 1, 0, ST_OK);
      dir_rows[16] = mk(REQ_SAMPLE, 1, 0, 100, 1, 0, ST_FIRST);
      dir_rows[17] = mk(REQ_SET, 1, 0, 0, 1, 0, ST_OK);
      dir_rows[18] = mk(REQ_REMOVE, 0, 0, 0, 1, 0, ST_BADID);

      // more ids than table entries so the full case comes up
      for (int i = 0; i < POOL_N; i++) begin
         pool_id[i] = ID_W'($urandom_range(99999, 1));
         pool_time[i] = '0;
      end
      pool_id[0] = 99999;
      pool_id[1] = 1;
      pool_id[2] = 17'h10000;

      phase_iv[0] = INTERVAL_RESET;
      phase_iv[1] = 36'd10000000;
      phase_iv[2] = 36'd1000;                     // below the sleep times reached
      phase_iv[3] = 36'd0;
      phase_iv[4] = 36'd1;
      phase_iv[5] = IV_MAX;
      phase_iv[6] = 36'd50000;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_req(dir_rows[i]);

      n_item = 0;
      for (int ph = 0; ph < 7; ph++) begin
         write_interval(phase_iv[ph]);
         for (int j = 0; j < N_RANDOM / 7; j++) begin
            steady_send = (n_item >= 700 && n_item < 1000);
            if (n_item == 1500) drain_rsp();
            n_item++;
            p = $urandom_range(POOL_N - 1);
            sel = $urandom_range(99);
            r = mk(REQ_SAMPLE, pool_id[p], LIM_W'($urandom_range(16'hFFFF)),
                   TIME_W'({$urandom, $urandom}));
            if (sel < 5) begin
               r.req = REQ_W'($urandom_range(2));
               r.id = ($urandom_range(3) == 0) ? 17'd0 : 17'($urandom_range(131071, 100000));
            end else if (sel < 8) begin
               r.req = REQ_RESET;
               r.id = ID_W'($urandom_range(131071));
            end else if (sel < 33) begin
               r.req = REQ_SET;
               if ($urandom_range(9) == 0) r.lim = 0;
               else if ($urandom_range(1)) r.lim = LIM_W'($urandom_range(8192, 1));
            end else if (sel < 38) begin
               r.req = REQ_REMOVE;
            end else if ($urandom_range(19) != 0) begin
               // well-formed: advance by roughly zero to four periods of load
               if (mdl_interval == 0) d = $urandom_range(1000000);
               else d = (longint'(mdl_interval) * $urandom_range(16383)) >> FRAC;
               pool_time[p] = pool_time[p] + d[TIME_W-1:0];
               r.tm = pool_time[p];
            end
            send_req(r);
         end
      end

      drain_rsp();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("cpu_share_throttle_controller_core_tb passed");
      end else begin
         $display("cpu_share_throttle_controller_core_tb failed");
      end
      $finish;
   end

endmodule
